@@ hw/rtl/edt_pkg.sv @@
package edt_pkg;

  // Pipeline depth, input register through output register.
  localparam int unsigned NumStages = 10;

  // Stage indices where the parallel time-of-day and date paths begin and end.
  localparam int unsigned FirstSplitStage = 3;
  localparam int unsigned LastStage = NumStages - 1;

  typedef logic [NumStages-1:0] stage_en_t;

  // Whole days since the epoch after saturation, 0..2932896.
  typedef logic [21:0] days_t;
  // Seconds within the day, 0..86399.
  typedef logic [16:0] sod_t;

endpackage

@@ hw/rtl/edt_split.sv @@
module edt_split import edt_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic [63:0] epoch_seconds_i,
  output days_t       days_o,
  output sod_t        sod_o
);

  // 86400 = 128 * 675: drop seven bits, then divide by 675 by reciprocal.
  localparam int unsigned LowBits = 7;
  localparam int unsigned DayRecipShift = 41;
  localparam logic [31:0] DayRecip =
      32'(((64'd1 << DayRecipShift) + 64'd674) / 64'd675);
  // First second that lands past 9999-12-31.
  localparam logic [62:0] SatSeconds = 63'((64'd2932896 + 64'd1) * 64'd86400);
  localparam days_t LastDay = 22'd2932896;
  localparam sod_t  LastSec = 17'd86399;

  // stage 0: clamp and split
  logic        sat0_q;
  logic [30:0] hi0_q;
  logic [6:0]  lo0_q;
  logic        neg;
  logic        sat_d;

  assign neg   = epoch_seconds_i[63];
  assign sat_d = !neg && (epoch_seconds_i[62:0] >= SatSeconds);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sat0_q <= sat_d;
      hi0_q  <= neg ? 31'd0 : epoch_seconds_i[LowBits+30:LowBits];
      lo0_q  <= neg ? 7'd0 : epoch_seconds_i[LowBits-1:0];
    end
  end

  // stage 1: quotient by reciprocal (exact for 31-bit dividends)
  logic [62:0] day_prod;
  logic [21:0] q1_q;
  logic [30:0] hi1_q;
  logic [6:0]  lo1_q;
  logic        sat1_q;

  assign day_prod = 63'(hi0_q) * 63'(DayRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q1_q   <= day_prod[DayRecipShift+21:DayRecipShift];
      hi1_q  <= hi0_q;
      lo1_q  <= lo0_q;
      sat1_q <= sat0_q;
    end
  end

  // stage 2: remainder, saturation
  logic [30:0] rem_full;
  days_t       days2_q;
  sod_t        sod2_q;

  assign rem_full = hi1_q - 31'(q1_q) * 31'd675;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      days2_q <= sat1_q ? LastDay : q1_q;
      sod2_q  <= sat1_q ? LastSec : {rem_full[9:0], lo1_q};
    end
  end

  assign days_o = days2_q;
  assign sod_o  = sod2_q;

endmodule

@@ hw/rtl/edt_tod.sv @@
module edt_tod import edt_pkg::*; (
  input  logic       clk_i,
  input  stage_en_t  en_i,
  input  sod_t       sod_i,
  output logic [5:0] second_o,
  output logic [5:0] minute_o,
  output logic [4:0] hour_o
);

  // Exact reciprocals for 17-bit dividends.
  localparam int unsigned HrShift = 29;
  localparam int unsigned MinShift = 23;
  localparam logic [17:0] HrRecip = 18'(((64'd1 << HrShift) + 64'd3599) / 64'd3600);
  localparam logic [17:0] MinRecip = 18'(((64'd1 << MinShift) + 64'd59) / 64'd60);
  localparam int unsigned DelayLen = LastStage - 1 - FirstSplitStage;

  // seconds of day wait here while the date path works
  sod_t sod_dly_q [DelayLen];

  always_ff @(posedge clk_i) begin
    if (en_i[FirstSplitStage]) begin
      sod_dly_q[0] <= sod_i;
    end
    for (int j = 1; j < DelayLen; j++) begin
      if (en_i[FirstSplitStage+j]) begin
        sod_dly_q[j] <= sod_dly_q[j-1];
      end
    end
  end

  // hours and total minutes
  logic [34:0] hr_prod;
  logic [34:0] min_prod;
  logic [4:0]  hr_q;
  logic [10:0] mt_q;
  sod_t        sod_q;

  assign hr_prod  = 35'(sod_dly_q[DelayLen-1]) * 35'(HrRecip);
  assign min_prod = 35'(sod_dly_q[DelayLen-1]) * 35'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[LastStage-1]) begin
      hr_q  <= hr_prod[HrShift+4:HrShift];
      mt_q  <= min_prod[MinShift+10:MinShift];
      sod_q <= sod_dly_q[DelayLen-1];
    end
  end

  // remainders
  sod_t        sec_full;
  logic [10:0] min_full;
  logic [5:0]  second_q;
  logic [5:0]  minute_q;
  logic [4:0]  hour_q;

  assign sec_full = sod_q - 17'(mt_q) * 17'd60;
  assign min_full = mt_q - 11'(hr_q) * 11'd60;

  always_ff @(posedge clk_i) begin
    if (en_i[LastStage]) begin
      second_q <= sec_full[5:0];
      minute_q <= min_full[5:0];
      hour_q   <= hr_q;
    end
  end

  assign second_o = second_q;
  assign minute_o = minute_q;
  assign hour_o   = hour_q;

endmodule

@@ hw/rtl/edt_date.sv @@
module edt_date import edt_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  days_t       days_i,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [13:0] year_o,
  output logic [2:0]  weekday_o
);

  localparam int unsigned S0 = FirstSplitStage;
  // days from March 1 of year 0, less the 59 days of Jan/Feb 1970
  localparam days_t MarchOffset = 22'd719468;

  localparam int unsigned WdShift = 25;
  localparam int unsigned YrShift = 49;
  localparam int unsigned CenShift = 17;
  localparam int unsigned MonShift = 21;
  localparam logic [22:0] WdRecip  = 23'(((64'd1 << WdShift) + 64'd6) / 64'd7);
  localparam logic [31:0] YrRecip  = 32'(((64'd1 << YrShift) + 64'd146096) / 64'd146097);
  localparam logic [12:0] CenRecip = 13'(((64'd1 << CenShift) + 64'd24) / 64'd25);
  localparam logic [12:0] MonRecip = 13'(((64'd1 << MonShift) + 64'd305) / 64'd306);

  // 367 * m / 12
  localparam logic [8:0] MonthBase [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
  };

  // stage A: shift origin, scale for year estimate, weekday quotient
  days_t       days4;
  days_t       dm;
  logic [44:0] wd_prod;
  days_t       dm_a_q;
  logic [30:0] yn_a_q;
  days_t       w4_a_q;
  logic [19:0] wq_a_q;

  assign days4   = days_i + 22'd4;
  assign dm      = days_i + MarchOffset;
  assign wd_prod = 45'(days4) * 45'(WdRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[S0]) begin
      dm_a_q <= dm;
      yn_a_q <= 31'((31'(dm) + 31'd2) * 31'd400);
      w4_a_q <= days4;
      wq_a_q <= wd_prod[WdShift+19:WdShift];
    end
  end

  // stage B: year estimate, weekday
  logic [62:0] yr_prod;
  days_t       wd_full;
  logic [13:0] y_b_q;
  days_t       dm_b_q;
  logic [2:0]  wd_b_q;

  assign yr_prod = 63'(yn_a_q) * 63'(YrRecip);
  assign wd_full = w4_a_q - 22'(wq_a_q) * 22'd7;

  always_ff @(posedge clk_i) begin
    if (en_i[S0+1]) begin
      y_b_q  <= yr_prod[YrShift+13:YrShift];
      dm_b_q <= dm_a_q;
      wd_b_q <= wd_full[2:0];
    end
  end

  // stage C: centuries
  logic [24:0] cen_prod;
  logic [6:0]  c_c_q;
  logic [13:0] y_c_q;
  days_t       dm_c_q;
  logic [2:0]  wd_c_q;

  assign cen_prod = 25'(y_b_q[13:2]) * 25'(CenRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[S0+2]) begin
      c_c_q  <= cen_prod[CenShift+6:CenShift];
      y_c_q  <= y_b_q;
      dm_c_q <= dm_b_q;
      wd_c_q <= wd_b_q;
    end
  end

  // stage D: day of March-based year, leap flag
  days_t              ysum;
  logic signed [22:0] ydr_full;
  logic               leap;
  logic signed [10:0] ydr_d_q;
  logic               leap_d_q;
  logic [13:0]        y_d_q;
  logic [2:0]         wd_d_q;

  assign ysum = 22'(y_c_q) * 22'd365 + 22'(y_c_q[13:2]) - 22'(c_c_q) + 22'(c_c_q[6:2]);
  assign ydr_full = $signed({1'b0, dm_c_q}) - $signed({1'b0, ysum});
  assign leap = (y_c_q[1:0] == 2'b00) &&
                ((y_c_q != 14'(c_c_q) * 14'd100) || (c_c_q[1:0] == 2'b00));

  always_ff @(posedge clk_i) begin
    if (en_i[S0+3]) begin
      ydr_d_q  <= ydr_full[10:0];
      leap_d_q <= leap;
      y_d_q    <= y_c_q;
      wd_d_q   <= wd_c_q;
    end
  end

  // stage E: overshoot correction, month scale
  logic [10:0] ydr_fix;
  logic [8:0]  yday;
  logic [13:0] y_fix;
  logic [8:0]  yday_e_q;
  logic [11:0] mn_e_q;
  logic [13:0] y_e_q;
  logic [2:0]  wd_e_q;

  always_comb begin
    ydr_fix = 11'(ydr_d_q) + 11'd365 + 11'(leap_d_q);
    if (ydr_d_q[10]) begin
      yday  = ydr_fix[8:0];
      y_fix = y_d_q - 14'd1;
    end else begin
      yday  = ydr_d_q[8:0];
      y_fix = y_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[S0+4]) begin
      yday_e_q <= yday;
      mn_e_q   <= 12'((12'(yday) + 12'd31) * 12'd10);
      y_e_q    <= y_fix;
      wd_e_q   <= wd_d_q;
    end
  end

  // stage F: month index from March
  logic [24:0] mon_prod;
  logic [3:0]  mon_f_q;
  logic [8:0]  yday_f_q;
  logic [13:0] y_f_q;
  logic [2:0]  wd_f_q;

  assign mon_prod = 25'(mn_e_q) * 25'(MonRecip);

  always_ff @(posedge clk_i) begin
    if (en_i[S0+5]) begin
      mon_f_q  <= mon_prod[MonShift+3:MonShift];
      yday_f_q <= yday_e_q;
      y_f_q    <= y_e_q;
      wd_f_q   <= wd_e_q;
    end
  end

  // stage G: day of month, back to January-based year
  logic [9:0]  mday_full;
  logic        jan_feb;
  logic [4:0]  mday_q;
  logic [3:0]  mon_q;
  logic [13:0] year_q;
  logic [2:0]  wday_q;

  assign mday_full = 10'(yday_f_q) + 10'd31 - 10'(MonthBase[mon_f_q]);
  assign jan_feb   = yday_f_q >= 9'd306;

  always_ff @(posedge clk_i) begin
    if (en_i[S0+6]) begin
      mday_q <= mday_full[4:0];
      mon_q  <= jan_feb ? mon_f_q - 4'd10 : mon_f_q + 4'd2;
      year_q <= jan_feb ? y_f_q + 14'd1 : y_f_q;
      wday_q <= wd_f_q;
    end
  end

  assign day_of_month_o = mday_q;
  assign month_o        = mon_q;
  assign year_o         = year_q;
  assign weekday_o      = wday_q;

endmodule

@@ hw/rtl/epoch_seconds_to_utc_date.sv @@
// Converts signed seconds since 1970-01-01 00:00:00 UTC to a broken-down
// Gregorian UTC date and time (second, minute, hour, day of month, month,
// year, weekday with Sunday = 0).
// Input channel: in_valid_i / in_stall_o carry epoch_seconds_i; a
// transaction completes on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry the seven date fields.
// Negative inputs come out as the epoch itself; anything past 9999-12-31
// comes out as 9999-12-31 23:59:59.
// Depth: 10 register stages, the first loading on the input edge.
// Throughput is one transaction per cycle while out_stall_i is low;
// the depth is set by the chain of reciprocal multiplies (day split,
// year estimate, century, month), one per stage.
// Stalling: each stage keeps its own valid bit and loads whenever it is
// empty or the stage after it moves, so bubbles close up behind a stalled
// result and the input keeps taking transactions until every stage holds
// one. in_stall_o rises only when the whole pipe is full and out_stall_i
// is high. A stalled result holds steady on the output.
// Reset empties the pipe (all valid bits clear); data registers are not
// reset.
module epoch_seconds_to_utc_date import edt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [13:0] year_o,
  output logic [2:0]  weekday_o
);

  // Per-stage valid bits and load enables.
  stage_en_t vld_q;
  stage_en_t load;

  // A stage may load when it is empty or its content moves on this edge.
  always_comb begin
    load[LastStage] = !vld_q[LastStage] || !out_stall_i;
    for (int k = LastStage - 1; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (load[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (load[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = vld_q[LastStage];

  // Front end: clamp, saturate, split into whole days and seconds of day.
  days_t days;
  sod_t  sod;

  edt_split u_split (
    .clk_i           (clk_i),
    .en_i            (load),
    .epoch_seconds_i (epoch_seconds_i),
    .days_o          (days),
    .sod_o           (sod)
  );

  // Time of day runs beside the date path and lands on the same stage.
  edt_tod u_tod (
    .clk_i    (clk_i),
    .en_i     (load),
    .sod_i    (sod),
    .second_o (second_o),
    .minute_o (minute_o),
    .hour_o   (hour_o)
  );

  // Calendar: weekday, year, month, day of month.
  edt_date u_date (
    .clk_i          (clk_i),
    .en_i           (load),
    .days_i         (days),
    .day_of_month_o (day_of_month_o),
    .month_o        (month_o),
    .year_o         (year_o),
    .weekday_o      (weekday_o)
  );

  // Input side stalls only with every stage occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a free pipeline stage");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) &&
                    (day_of_month_o >= 5'd1) && (weekday_o < 3'd7) &&
                    (year_o >= 14'd1970) && (year_o <= 14'd9999))
    else $error("date field out of range");

  a_feb_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (month_o == 4'd2)) |-> (day_of_month_o <= 5'd29))
    else $error("February day past 29");

endmodule
